/* src/cbd_pkg.sv */
// cbd_pkg: shared types and constants of the clap burst detector
// no dependencies

package cbd_pkg;

  localparam int ThresholdWidth = 15;
  localparam int CountWidth     = 12;
  localparam int RunWidth       = 13;
  localparam int ElapsedWidth   = 13;
  localparam int TotalWidth     = 16;
  localparam int GroupWidth     = 2;
  localparam int CfgIndexWidth  = 2;
  localparam int CfgDataWidth   = 15;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  localparam logic [CfgIndexWidth-1:0] REG_PEAK_THRESHOLD  = 2'd0;
  localparam logic [CfgIndexWidth-1:0] REG_HOLDOFF_SAMPLES = 2'd1;
  localparam logic [CfgIndexWidth-1:0] REG_NOISE_RUN_LIMIT = 2'd2;
  localparam logic [CfgIndexWidth-1:0] REG_GROUP_GAP_MS    = 2'd3;

  localparam logic [ThresholdWidth-1:0] PEAK_THRESHOLD_RESET  = 15'd16000;
  localparam logic [CountWidth-1:0]     HOLDOFF_SAMPLES_RESET = 12'd1000;
  localparam logic [CountWidth-1:0]     NOISE_RUN_LIMIT_RESET = 12'd2000;
  localparam logic [CountWidth-1:0]     GROUP_GAP_MS_RESET    = 12'd1000;

  localparam logic [GroupWidth-1:0]   GROUP_MAX   = 2'd3;
  localparam logic [ElapsedWidth-1:0] ELAPSED_MAX = 13'h1fff;

  typedef struct packed {
    logic [ThresholdWidth-1:0] peak_threshold;
    logic [CountWidth-1:0]     holdoff_samples;
    logic [CountWidth-1:0]     noise_run_limit;
    logic [CountWidth-1:0]     group_gap_ms;
  } cfg_t;

  typedef struct packed {
    logic                  clap_detected;
    logic                  noise_detected;
    logic [TotalWidth-1:0] clap_total;
    logic [GroupWidth-1:0] group_count;
    logic                  group_done;
  } res_t;

endpackage

/* src/clap_burst_detector.sv */
// clap_burst_detector: top level, input register, detector and result register
// an accepted item passes the input register, then the detector into the result register
// throughput: one item per cycle when out_ready does not stall the result stage
// reset: synchronous active-high rst clears all counters, flags and both stages,
// and loads the configuration registers with their defaults
// depends on cbd_pkg, cbd_cfg_regs, cbd_detect

module clap_burst_detector #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [cbd_pkg::CfgIndexWidth-1:0]   cfg_index,
  input  logic [cbd_pkg::CfgDataWidth-1:0]    cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                operation,
  input  logic signed [SAMPLE_WIDTH-1:0]      sample,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                clap_detected,
  output logic                                noise_detected,
  output logic [cbd_pkg::TotalWidth-1:0]      clap_total,
  output logic [cbd_pkg::GroupWidth-1:0]      group_count,
  output logic                                group_done
);
  import cbd_pkg::*;

  cfg_t                    cfg;
  res_t                    res;
  res_t                    res_q;
  logic                    s1_valid;
  logic                    s1_operation;
  logic [SAMPLE_WIDTH-1:0] s1_sample;
  logic                    s1_fire;

  assign s1_fire  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_fire;

  cbd_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  cbd_detect #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_detect (
    .clk       (clk),
    .rst       (rst),
    .step      (s1_fire),
    .operation (s1_operation),
    .sample    (s1_sample),
    .cfg       (cfg),
    .res       (res)
  );

  // input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_operation <= operation;
      s1_sample    <= sample;
    end
  end

  // result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      res_q <= res;
    end
  end

  assign clap_detected  = res_q.clap_detected;
  assign noise_detected = res_q.noise_detected;
  assign clap_total     = res_q.clap_total;
  assign group_count    = res_q.group_count;
  assign group_done     = res_q.group_done;

endmodule

/* src/cbd_cfg_regs.sv */
// cbd_cfg_regs: configuration registers of the clap burst detector
// depends on cbd_pkg

module cbd_cfg_regs (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [cbd_pkg::CfgIndexWidth-1:0]    cfg_index,
  input  logic [cbd_pkg::CfgDataWidth-1:0]     cfg_data,
  output cbd_pkg::cfg_t                        cfg
);
  import cbd_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.peak_threshold  <= PEAK_THRESHOLD_RESET;
      cfg.holdoff_samples <= HOLDOFF_SAMPLES_RESET;
      cfg.noise_run_limit <= NOISE_RUN_LIMIT_RESET;
      cfg.group_gap_ms    <= GROUP_GAP_MS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PEAK_THRESHOLD:  cfg.peak_threshold  <= cfg_data[ThresholdWidth-1:0];
        REG_HOLDOFF_SAMPLES: cfg.holdoff_samples <= cfg_data[CountWidth-1:0];
        REG_NOISE_RUN_LIMIT: cfg.noise_run_limit <= cfg_data[CountWidth-1:0];
        REG_GROUP_GAP_MS:    cfg.group_gap_ms    <= cfg_data[CountWidth-1:0];
        default: ;
      endcase
    end
  end

endmodule

/* src/cbd_detect.sv */
// cbd_detect: run measurement, hold-off, clap counting and group timer
// depends on cbd_pkg

module cbd_detect #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    step,
  input  logic                    operation,
  input  logic [SAMPLE_WIDTH-1:0] sample,
  input  cbd_pkg::cfg_t           cfg,
  output cbd_pkg::res_t           res
);
  import cbd_pkg::*;

  localparam int CmpWidth = (SAMPLE_WIDTH > ThresholdWidth) ? SAMPLE_WIDTH : ThresholdWidth;

  logic [RunWidth-1:0]     run_length,     run_length_next;
  logic [CountWidth-1:0]   holdoff_left,   holdoff_left_next;
  logic [TotalWidth-1:0]   total_claps,    total_claps_next;
  logic [GroupWidth-1:0]   claps_in_group, claps_in_group_next;
  logic                    group_active,   group_active_next;
  logic [ElapsedWidth-1:0] elapsed_ms,     elapsed_ms_next;

  logic [SAMPLE_WIDTH-1:0] magnitude;
  logic                    loud;
  logic                    hold;
  logic                    within_limit;
  logic [RunWidth-1:0]     limit_ext;
  logic [RunWidth-1:0]     run_inc;
  logic [ElapsedWidth-1:0] elapsed_inc;

  assign magnitude    = sample[SAMPLE_WIDTH-1] ? (~sample + 1'b1) : sample;
  assign loud         = CmpWidth'(magnitude) > CmpWidth'(cfg.peak_threshold);
  assign hold         = holdoff_left != '0;
  assign limit_ext    = RunWidth'(cfg.noise_run_limit);
  assign within_limit = run_length <= limit_ext;
  assign run_inc      = run_length + 1'b1;
  assign elapsed_inc  = (elapsed_ms == ELAPSED_MAX) ? elapsed_ms : elapsed_ms + 1'b1;

  always_comb begin
    run_length_next     = run_length;
    holdoff_left_next   = holdoff_left;
    total_claps_next    = total_claps;
    claps_in_group_next = claps_in_group;
    group_active_next   = group_active;
    elapsed_ms_next     = elapsed_ms;
    res                 = '0;
    res.group_count     = claps_in_group;

    if (operation == OP_SAMPLE) begin
      if (hold) begin
        holdoff_left_next = holdoff_left - 1'b1;
      end
      if (loud) begin
        if (within_limit) begin
          run_length_next    = run_inc;
          res.noise_detected = run_inc > limit_ext;
        end
      end else if (run_length != '0) begin
        if (within_limit && !hold) begin
          res.clap_detected = 1'b1;
          total_claps_next  = total_claps + 1'b1;
          if (claps_in_group != GROUP_MAX) begin
            claps_in_group_next = claps_in_group + 1'b1;
          end
          holdoff_left_next = cfg.holdoff_samples;
          group_active_next = 1'b1;
          elapsed_ms_next   = '0;
        end
        run_length_next = '0;
      end
      res.group_count = claps_in_group_next;
    end else if (group_active) begin
      elapsed_ms_next = elapsed_inc;
      if (elapsed_inc > ElapsedWidth'(cfg.group_gap_ms)) begin
        res.group_done      = 1'b1;
        claps_in_group_next = '0;
        group_active_next   = 1'b0;
        elapsed_ms_next     = '0;
      end
    end
    res.clap_total = total_claps_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_length     <= '0;
      holdoff_left   <= '0;
      total_claps    <= '0;
      claps_in_group <= '0;
      group_active   <= 1'b0;
      elapsed_ms     <= '0;
    end else if (step) begin
      run_length     <= run_length_next;
      holdoff_left   <= holdoff_left_next;
      total_claps    <= total_claps_next;
      claps_in_group <= claps_in_group_next;
      group_active   <= group_active_next;
      elapsed_ms     <= elapsed_ms_next;
    end
  end

endmodule

/* src/cbd_checker.sv */
// cbd_checker: port-level assertions for clap_burst_detector, bound to the top
// no dependencies

module cbd_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic       clap_detected,
  input logic       noise_detected,
  input logic [1:0] group_count,
  input logic       group_done
);

  // a pending result is held until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before it was taken");

  // a sample item cannot close a group, a tick cannot end a clap
  a_clap_not_done: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(clap_detected && group_done))
    else $error("clap and group close on one item");

  // a run ending a clap cannot also be growing past the limit
  a_clap_not_noise: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(clap_detected && noise_detected))
    else $error("clap and noise on one item");

  // a closed group or a fresh clap always shows a nonzero count
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (clap_detected || group_done) |-> group_count != 2'd0)
    else $error("group count zero on clap or group close");

endmodule

bind clap_burst_detector cbd_checker u_cbd_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .clap_detected  (clap_detected),
  .noise_detected (noise_detected),
  .group_count    (group_count),
  .group_done     (group_done)
);
